// ----- hdl/lgs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Types, constants and rule functions shared by the Life stencil unit.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int GRID_W_BITS = 8;
    localparam int GRID_H_BITS = 13;

    localparam logic [GRID_W_BITS-1:0] GRID_WIDTH_RESET  = 8'd100;
    localparam logic [GRID_H_BITS-1:0] GRID_HEIGHT_RESET = 13'd40;

    localparam int MIN_WIDTH  = 3;
    localparam int MIN_HEIGHT = 3;

    // B3/S23
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    // Result queue depth
    localparam int QDEPTH = 3;

    typedef logic [8:0] window_t;

    // Control flags carried from the read stage to the update stage
    typedef struct packed {
        logic c_zero;
        logic r_ge1;
        logic r_ge2;
        logic live;
        logic emit;
        logic last;
    } stage_t;

    typedef struct packed {
        logic last;
        logic alive;
    } result_t;

    // Window bit row*3+col, col 0 oldest; shift one column and insert the new one
    function automatic window_t shift_in(input window_t w, input logic top,
                                         input logic mid, input logic bot);
        window_t res;
        res[0] = w[1];
        res[1] = w[2];
        res[2] = top;
        res[3] = w[4];
        res[4] = w[5];
        res[5] = mid;
        res[6] = w[7];
        res[7] = w[8];
        res[8] = bot;
        return res;
    endfunction

    function automatic logic life_rule(input window_t w);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                n = n + 4'(w[i]);
            end
        end
        return (n == 4'(BIRTH_COUNT)) || (w[4] && (n == 4'(SURVIVE_COUNT)));
    endfunction

endpackage

// ----- hdl/lgs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/life_generation_stencil_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_stencil_unit
// One generation of Conway's Life (B3/S23) over a raster cell stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one cell per transfer: tdata[0] is the cell state, tuser
//   flags a pad transfer that counts as a dead cell. Cells arrive in raster
//   order; after each frame send grid_width+1 pads to flush the last row.
//   m_axis returns the next-generation state in tdata[0]; tlast marks the
//   bottom-right cell of the frame. The result for a cell follows one row
//   plus one cell of input transfers later.
//   Throughput is one cell per cycle while the result queue has room: both
//   line buffers sit in one 2-bit RAM that takes one read and one write per
//   cycle. Each result is registered in the update stage, then in the queue.
//   A three-entry result queue decouples the sides; s_axis stays ready
//   while the receiver stalls until that queue fills, then holds off.
//   Reset loads width 100 and height 40 and starts a frame at row 0.
//   A write to cfg restarts the frame; write only while the unit is idle.
//   The line buffer RAM needs no clearing: rows not yet written are masked.
// ----------------------------------------------------------------------------
module life_generation_stencil_unit #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [0] cell_alive
    input  logic                           s_axis_tuser,  // [0] pad_item
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [0] next_alive
    output logic                           m_axis_tlast,  // last_of_frame
    // configuration
    input  logic                           cfg_we,
    input  logic [lgs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lgs_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [GRID_W_BITS-1:0] grid_width_reg;
    logic [GRID_H_BITS-1:0] grid_height_reg;
    logic [WW-1:0]          eff_w;
    logic [RW-1:0]          eff_h;

    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic          in_xfer;
    stage_t        s0;
    stage_t        s1_reg;
    logic          s1_valid_reg;
    logic [AW-1:0] s1_addr_reg;

    logic [1:0] rd_data;
    logic [1:0] wr_data;
    logic       top, mid;
    window_t    window_reg, window_next, win_flush;
    result_t    result;
    logic       push, pop;

    result_t    q_data_reg [QDEPTH];
    logic [1:0] q_wr_reg, q_rd_reg, q_count_reg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[GRID_W_BITS-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[GRID_H_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Saturate the registers into the usable range
    always_comb
    begin
        if (32'(grid_width_reg) < 32'(MIN_WIDTH))
            eff_w = WW'(MIN_WIDTH);
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(grid_width_reg);

        if (32'(grid_height_reg) < 32'(MIN_HEIGHT))
            eff_h = RW'(MIN_HEIGHT);
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(grid_height_reg);
    end

    // ------------------------------------------------------------------
    // Read stage: position counters and line buffer read
    // ------------------------------------------------------------------
    assign s_axis_tready = (3'(q_count_reg) + 3'(s1_valid_reg)) < 3'(QDEPTH);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        s0.c_zero = (col_reg == '0);
        s0.r_ge1  = (row_reg != '0);
        s0.r_ge2  = (32'(row_reg) >= 32'd2);
        s0.live   = s_axis_tdata[0] && !s_axis_tuser && (32'(row_reg) < 32'(eff_h));
        s0.last   = s0.c_zero && (32'(row_reg) == 32'(eff_h) + 32'd1);
        s0.emit   = s0.c_zero ? s0.r_ge2
                              : (s0.r_ge1 && (32'(row_reg) <= 32'(eff_h)));

        col_next = col_reg;
        row_next = row_reg;
        if (s0.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (32'(col_reg) + 32'd1 >= 32'(eff_w))
        begin
            col_next = '0;
            // hold at the flush row (eff_h+1) until the last result leaves
            if (32'(row_reg) != 32'(eff_h) + 32'd1)
                row_next = row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_xfer;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_reg      <= s0;
            s1_addr_reg <= col_reg;
        end
    end

    // Line buffers: bit 1 upper line, bit 0 middle line
    lgs_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .re    (in_xfer),
        .raddr (col_reg),
        .rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Update stage: window, rule, write-back
    // ------------------------------------------------------------------
    always_comb
    begin
        top     = s1_reg.r_ge2 && rd_data[1];
        mid     = s1_reg.r_ge1 && rd_data[0];
        wr_data = {mid, s1_reg.live};

        win_flush   = shift_in(window_reg, 1'b0, 1'b0, 1'b0);
        window_next = shift_in(s1_reg.c_zero ? '0 : window_reg, top, mid, s1_reg.live);

        result.last  = s1_reg.last;
        result.alive = s1_reg.c_zero ? life_rule(win_flush) : life_rule(window_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (cfg_we)
            window_reg <= '0;
        else if (s1_valid_reg)
            window_reg <= s1_reg.last ? '0 : window_next;
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign push = s1_valid_reg && s1_reg.emit;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (push)
            q_data_reg[q_wr_reg] <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            if (push)
                q_wr_reg <= (q_wr_reg == 2'(QDEPTH - 1)) ? '0 : q_wr_reg + 2'd1;
            if (pop)
                q_rd_reg <= (q_rd_reg == 2'(QDEPTH - 1)) ? '0 : q_rd_reg + 2'd1;
            if (push && !pop)
                q_count_reg <= q_count_reg + 2'd1;
            else if (pop && !push)
                q_count_reg <= q_count_reg - 2'd1;
        end
    end

    assign m_axis_tvalid = (q_count_reg != '0);
    assign m_axis_tdata  = {7'd0, q_data_reg[q_rd_reg].alive};
    assign m_axis_tlast  = q_data_reg[q_rd_reg].last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> q_count_reg < 2'(QDEPTH))
        else $error("result queue overflow");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(eff_w))
        else $error("column counter beyond grid width");

    a_row_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) <= 32'(eff_h) + 32'd1)
        else $error("row counter beyond flush row");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.last |-> col_reg == '0 && row_reg == '0)
        else $error("frame did not restart after last cell");

endmodule
